// ===== hdl/rfpte_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpte_pkg: shared types and constants of the pulse train encoder
// Word layouts, configuration register map, pulse phase codes and the item
// passed from the front end to the pulse sequencer.
// ----------------------------------------------------------------------------
package rfpte_pkg;

  // Parameter defaults
  localparam int MAX_BITS_DEF  = 64;
  localparam int TICK_BITS_DEF = 16;

  // Fixed field widths
  localparam int MSG_W = 64;
  localparam int FS_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 32;

  // Input word: message, then keep_going, padded to whole bytes
  localparam int IN_FIELDS_W = MSG_W + 1;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result word: tx_level, busy_res, done_res, frames_sent
  localparam int OUT_FIELDS_W = 3 + FS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Depth of the queue between front end and sequencer
  localparam int QUEUE_DEPTH = 2;

  // Line mode register mask
  localparam logic [2:0] MODE_MASK = 3'h7;

  // Line codes (line_mode bits 1:0; the unused code is sent as tribit)
  localparam logic [1:0] CODE_TRIBIT = 2'd0;
  localparam logic [1:0] CODE_INV    = 2'd1;
  localparam logic [1:0] CODE_MANCH  = 2'd2;
  localparam logic [1:0] CODE_SPARE  = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_MODE    = 3'd0,
    CFG_BIT_COUNT    = 3'd1,
    CFG_REPEAT_COUNT = 3'd2,
    CFG_INIT_GAP     = 3'd3,
    CFG_PREFIX       = 3'd4,
    CFG_SL_LOW       = 3'd5,
    CFG_SL_HIGH      = 3'd6,
    CFG_EDGE         = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]       line_mode;
    logic [6:0]       bit_count;
    logic [7:0]       repeat_count;
    logic [CFG_W-1:0] init_and_gap_ticks;
    logic [CFG_W-1:0] prefix_ticks;
    logic [CFG_W-1:0] short_long_low_ticks;
    logic [CFG_W-1:0] short_long_high_ticks;
    logic [CFG_W-1:0] edge_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    line_mode:             3'd0,
    bit_count:             7'd32,
    repeat_count:          8'd1,
    init_and_gap_ticks:    '0,
    prefix_ticks:          '0,
    short_long_low_ticks:  '0,
    short_long_high_ticks: '0,
    edge_ticks:            '0
  };

  // Item kinds
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [MSG_W-1:0] message;
    logic             keep_going;
  } item_t;

  // Head of the queue as seen by the sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Pulse phases, one-hot
  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_INIT   = 11'b000_0000_0010,
    PH_FRAME  = 11'b000_0000_0100,
    PH_PRE_HI = 11'b000_0000_1000,
    PH_PRE_LO = 11'b000_0001_0000,
    PH_LEAD   = 11'b000_0010_0000,
    PH_BIT_A  = 11'b000_0100_0000,
    PH_BIT_B  = 11'b000_1000_0000,
    PH_TRAIL  = 11'b001_0000_0000,
    PH_SEP    = 11'b010_0000_0000,
    PH_END    = 11'b100_0000_0000
  } phase_t;

endpackage

// ===== hdl/rfpte_front.sv =====
// ----------------------------------------------------------------------------
// rfpte_front: input front end
// Accepts input words, decodes them into tick or start items and holds them
// in a short queue so that the sequencer and the input side stall apart.
// ----------------------------------------------------------------------------
module rfpte_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rfpte_pkg::IN_TDATA_W-1:0] in_tdata,  // [63:0] message, [64] keep_going
  input  logic                            in_tuser,  // [0] operation
  input  logic                            pop_i,
  output rfpte_pkg::q_head_t              head_o
);
  import rfpte_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push;
  item_t             in_item;

  // Decode the incoming word
  always_comb begin
    in_item.op         = op_t'(in_tuser);
    in_item.message    = in_tdata[MSG_W-1:0];
    in_item.keep_going = in_tdata[MSG_W];
  end

  assign in_tready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;

  assign head_o.valid = (count_r != '0);
  assign head_o.item  = q_mem_r[rd_ptr_r];

  // Pointer and fill arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("pop from empty queue");

endmodule

// ===== hdl/rfpte_back.sv =====
// ----------------------------------------------------------------------------
// rfpte_back: pulse sequencer
// Carries out queued items: counts down the current pulse, steps through the
// pulse train's phases one per cycle while the output register is free, skipping
// zero-length pulses, and places one result word per item into the output register.
// ----------------------------------------------------------------------------
module rfpte_back #(
  parameter int MAX_BITS  = rfpte_pkg::MAX_BITS_DEF,
  parameter int TICK_BITS = rfpte_pkg::TICK_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rfpte_pkg::cfg_t                  cfg_i,
  input  rfpte_pkg::q_head_t               head_i,
  output logic                             pop_o,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rfpte_pkg::OUT_TDATA_W-1:0] out_tdata  // [0] tx_level, [1] busy_res,
                                                       // [2] done_res, [18:3] frames_sent
);
  import rfpte_pkg::*;

  localparam int BP_W  = $clog2(MAX_BITS + 1);
  localparam int IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int DUR_W = (TICK_BITS < 16) ? TICK_BITS : 16;

  typedef struct packed {
    phase_t          ph;
    logic [BP_W-1:0] bp;
  } step_t;

  // Duration halves, masked to the tick width
  function automatic logic [DUR_W-1:0] lo_d(input logic [CFG_W-1:0] r);
    return r[DUR_W-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] hi_d(input logic [CFG_W-1:0] r);
    return r[16+DUR_W-1:16];
  endfunction

  // Phase order of the pulse train
  function automatic step_t next_phase(input phase_t ph, input logic [BP_W-1:0] bp,
                                       input logic [1:0] kind, input logic [BP_W-1:0] nb,
                                       input logic pre_on);
    step_t s;
    s.ph = ph;
    s.bp = bp;
    unique case (ph)
      PH_INIT:   s.ph = PH_FRAME;
      PH_FRAME, PH_PRE_LO: begin
        if (ph == PH_FRAME && pre_on) begin
          s.ph = PH_PRE_HI;
        end else if (kind == CODE_INV) begin
          s.ph = PH_LEAD;
        end else begin
          s.bp = (kind == CODE_MANCH) ? nb : nb - 1'b1;
          s.ph = PH_BIT_A;
        end
      end
      PH_PRE_HI: s.ph = PH_PRE_LO;
      PH_LEAD: begin
        s.bp = nb - 1'b1;
        s.ph = PH_BIT_A;
      end
      PH_BIT_A:  s.ph = PH_BIT_B;
      PH_BIT_B: begin
        if (bp != '0) begin
          s.bp = bp - 1'b1;
          s.ph = PH_BIT_A;
        end else begin
          s.ph = (kind == CODE_TRIBIT) ? PH_TRAIL : PH_SEP;
        end
      end
      PH_TRAIL:  s.ph = PH_SEP;
      default:   s.ph = PH_END;
    endcase
    return s;
  endfunction

  // Sequencer state
  logic              active_r, active_nxt;
  logic [MAX_BITS-1:0] data_r, data_nxt;
  logic [BP_W-1:0]   bp_r, bp_nxt;
  phase_t            phase_r, phase_nxt;
  logic [DUR_W-1:0]  ticks_r, ticks_nxt;
  logic [FS_W-1:0]   fc_r, fc_nxt;
  logic              level_r, level_nxt;
  logic              crossed_r, crossed_nxt;
  logic              walking_r, walking_nxt;

  // Output register
  logic              out_valid_r;
  logic              out_level_r, out_busy_r, out_done_r;
  logic [FS_W-1:0]   out_fs_r;

  // Decoded configuration
  logic [1:0]        kind;
  logic              inv;
  logic [BP_W-1:0]   nb;
  logic              pre_on;
  logic [DUR_W-1:0]  ls, ll, hs, hl;

  // State as seen after the item's first action
  logic              v_active;
  logic [MAX_BITS-1:0] v_data;
  logic [BP_W-1:0]   v_bp;
  phase_t            v_phase;
  logic [DUR_W-1:0]  v_ticks;
  logic [FS_W-1:0]   v_fc;
  logic              v_level;
  logic              v_crossed;
  logic              walk;
  step_t             np_entry, np_walk;

  logic              cbit;
  logic [DUR_W-1:0]  plen;
  logic              plvl;
  logic              cont;
  logic              done;
  logic              step_en;

  // Configuration decode
  always_comb begin
    kind   = (cfg_i.line_mode[1:0] == CODE_SPARE) ? CODE_TRIBIT : cfg_i.line_mode[1:0];
    inv    = cfg_i.line_mode[2];
    pre_on = (lo_d(cfg_i.prefix_ticks) != '0);
    if (cfg_i.bit_count == '0) begin
      nb = BP_W'(1);
    end else if (cfg_i.bit_count > 7'(MAX_BITS)) begin
      nb = BP_W'(MAX_BITS);
    end else begin
      nb = BP_W'(cfg_i.bit_count);
    end
    ls = lo_d(cfg_i.short_long_low_ticks);
    ll = hi_d(cfg_i.short_long_low_ticks);
    if (lo_d(cfg_i.short_long_high_ticks) != '0) begin
      hs = lo_d(cfg_i.short_long_high_ticks);
      hl = hi_d(cfg_i.short_long_high_ticks);
    end else begin
      hs = ls;
      hl = ll;
    end
  end

  assign step_en = head_i.valid && (!out_valid_r || out_tready);

  // First action of an item, or the registered state while walking
  always_comb begin
    np_entry  = next_phase(phase_r, bp_r, kind, nb, pre_on);
    v_active  = active_r;
    v_data    = data_r;
    v_bp      = bp_r;
    v_phase   = phase_r;
    v_ticks   = ticks_r;
    v_fc      = fc_r;
    v_level   = level_r;
    v_crossed = crossed_r;
    walk      = 1'b0;
    if (walking_r) begin
      walk = 1'b1;
    end else if (head_i.item.op == OP_START) begin
      v_data    = head_i.item.message[MAX_BITS-1:0];
      v_active  = 1'b1;
      v_fc      = '0;
      v_bp      = '0;
      v_phase   = PH_INIT;
      v_crossed = 1'b0;
      walk      = 1'b1;
    end else if (active_r) begin
      v_crossed = 1'b0;
      if (ticks_r > DUR_W'(1)) begin
        v_ticks = ticks_r - 1'b1;
      end else begin
        v_ticks = '0;
        v_phase = np_entry.ph;
        v_bp    = np_entry.bp;
        walk    = 1'b1;
      end
    end
  end

  // Length and level of the phase in view
  always_comb begin
    cbit = 1'b0;
    if (!(kind == CODE_MANCH && v_bp == nb)) begin
      if (v_bp < BP_W'(MAX_BITS)) begin
        cbit = v_data[v_bp[IDX_W-1:0]] ^ inv;
      end else begin
        cbit = inv;
      end
    end
    plen = '0;
    plvl = 1'b0;
    unique case (v_phase)
      PH_INIT:   plen = lo_d(cfg_i.init_and_gap_ticks);
      PH_PRE_HI: begin
        plen = lo_d(cfg_i.prefix_ticks);
        plvl = 1'b1;
      end
      PH_PRE_LO: plen = hi_d(cfg_i.prefix_ticks);
      PH_LEAD: begin
        plen = lo_d(cfg_i.edge_ticks);
        plvl = 1'b1;
      end
      PH_TRAIL: begin
        plen = hi_d(cfg_i.edge_ticks);
        plvl = 1'b1;
      end
      PH_SEP:    plen = hi_d(cfg_i.init_and_gap_ticks);
      PH_BIT_A, PH_BIT_B: begin
        if (kind == CODE_MANCH) begin
          plen = ls;
          plvl = (v_phase == PH_BIT_A) ? ~cbit : cbit;
        end else if (kind == CODE_TRIBIT) begin
          if (v_phase == PH_BIT_A) begin
            plen = cbit ? ll : ls;
            plvl = 1'b1;
          end else begin
            plen = cbit ? hs : hl;
          end
        end else begin
          if (v_phase == PH_BIT_A) begin
            plen = cbit ? hl : hs;
          end else begin
            plen = cbit ? ls : ll;
            plvl = 1'b1;
          end
        end
      end
      default:   plen = '0;
    endcase
  end

  // One walking step: frame end handling or move past a zero-length pulse
  always_comb begin
    np_walk     = next_phase(v_phase, v_bp, kind, nb, pre_on);
    active_nxt  = v_active;
    data_nxt    = v_data;
    bp_nxt      = v_bp;
    phase_nxt   = v_phase;
    ticks_nxt   = v_ticks;
    fc_nxt      = v_fc;
    level_nxt   = v_level;
    crossed_nxt = v_crossed;
    cont        = 1'b0;
    done        = 1'b0;
    if (walk) begin
      if (v_phase == PH_END) begin
        fc_nxt = (v_fc != '1) ? v_fc + 1'b1 : v_fc;
        if ((cfg_i.repeat_count != '0 && fc_nxt == FS_W'(cfg_i.repeat_count)) ||
            !head_i.item.keep_going) begin
          active_nxt = 1'b0;
          phase_nxt  = PH_IDLE;
          ticks_nxt  = '0;
          level_nxt  = 1'b0;
          done       = 1'b1;
        end else begin
          phase_nxt = PH_FRAME;
          if (v_crossed) begin
            // second frame end in one item: hold low until the next tick
            ticks_nxt = '0;
            level_nxt = 1'b0;
          end else begin
            crossed_nxt = 1'b1;
            cont        = 1'b1;
          end
        end
      end else if (plen != '0) begin
        ticks_nxt = plen;
        level_nxt = plvl;
      end else begin
        phase_nxt = np_walk.ph;
        bp_nxt    = np_walk.bp;
        cont      = 1'b1;
      end
    end
    walking_nxt = cont;
  end

  assign pop_o = step_en && !cont;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      bp_r        <= '0;
      phase_r     <= PH_IDLE;
      ticks_r     <= '0;
      fc_r        <= '0;
      level_r     <= 1'b0;
      crossed_r   <= 1'b0;
      walking_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en) begin
        active_r  <= active_nxt;
        bp_r      <= bp_nxt;
        phase_r   <= phase_nxt;
        ticks_r   <= ticks_nxt;
        fc_r      <= fc_nxt;
        level_r   <= level_nxt;
        crossed_r <= crossed_nxt;
        walking_r <= walking_nxt;
      end
      if (step_en && !cont) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Message and result payload, no reset
  always_ff @(posedge clk) begin
    if (step_en) begin
      data_r <= data_nxt;
    end
    if (step_en && !cont) begin
      out_level_r <= level_nxt;
      out_busy_r  <= active_nxt;
      out_done_r  <= done;
      out_fs_r    <= fc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_fs_r, out_done_r, out_busy_r, out_level_r};

  // Checks
  a_walk_active: assert property (@(posedge clk) disable iff (!rst_n)
    walking_r |-> active_r)
    else $error("sequencer walking with no transmission");

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (phase_r == PH_IDLE))
    else $error("phase not idle while inactive");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (bp_r <= BP_W'(MAX_BITS)))
    else $error("bit position out of range");

  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (!out_busy_r && out_fs_r != '0))
    else $error("finishing word still busy or with no frame");

endmodule

// ===== hdl/rf_pulse_train_encoder_core.sv =====
// ----------------------------------------------------------------------------
// rf_pulse_train_encoder_core: on-off keying pulse train encoder
// Configuration registers, input front end and pulse sequencer.
// ----------------------------------------------------------------------------
// One result word comes out for every input word, in the cycle after the
// sequencer takes it. Ticks that only count down the current pulse, or
// that land straight on a pulse of nonzero length, run at one word per
// clock while the output is accepted. The sequencer walks the pulse phases
// one per cycle while the output is accepted, so every zero-length pulse
// skipped and every frame end crossed holds that word back longer, also for
// a start or tick passing over a frame made wholly of empty pulses. A
// two-word queue in front of the sequencer and the output register let the
// input keep flowing meanwhile. Write configuration only between
// transmissions' words, not while one is in flight.
module rf_pulse_train_encoder_core #(
  parameter int MAX_BITS  = rfpte_pkg::MAX_BITS_DEF,
  parameter int TICK_BITS = rfpte_pkg::TICK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rfpte_pkg::IN_TDATA_W-1:0]  in_tdata,   // [63:0] message, [64] keep_going
  input  logic                              in_tuser,   // [0] operation
  // result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rfpte_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] tx_level, [1] busy_res,
                                                        // [2] done_res, [18:3] frames_sent
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rfpte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfpte_pkg::CFG_W-1:0]       cfg_data
);
  import rfpte_pkg::*;

  cfg_t    cfg_r;
  q_head_t head;
  logic    pop;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_MODE:    cfg_r.line_mode             <= cfg_data[2:0] & MODE_MASK;
        CFG_BIT_COUNT:    cfg_r.bit_count             <= cfg_data[6:0];
        CFG_REPEAT_COUNT: cfg_r.repeat_count          <= cfg_data[7:0];
        CFG_INIT_GAP:     cfg_r.init_and_gap_ticks    <= cfg_data;
        CFG_PREFIX:       cfg_r.prefix_ticks          <= cfg_data;
        CFG_SL_LOW:       cfg_r.short_long_low_ticks  <= cfg_data;
        CFG_SL_HIGH:      cfg_r.short_long_high_ticks <= cfg_data;
        CFG_EDGE:         cfg_r.edge_ticks            <= cfg_data;
      endcase
    end
  end

  // Front end: decode and queue
  rfpte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop_i     (pop),
    .head_o    (head)
  );

  // Pulse sequencer and result register
  rfpte_back #(
    .MAX_BITS  (MAX_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .head_i     (head),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
